/* rtl/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* rtl/amsl_pkg.sv */
// Shared constants and types for the audio mix soft limiter.
`default_nettype none

package amsl_pkg;

  localparam int unsigned SampleBitsDef = 16;

  // limiter factor, unsigned Q1.16
  localparam logic [16:0] FacOne     = 17'd65536;
  localparam logic [16:0] FacMin     = 17'd39321;  // 0.6
  localparam logic [16:0] FacNearOne = 17'd64880;  // 0.99

  localparam logic [14:0] ThreshReset = 15'd32439;

  // recovery: inv' = inv*(inv + 9*65536) / (10*65536)
  localparam logic [19:0] TickAdd = 20'd589824;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/amsl_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module amsl_div import amsl_pkg::*; #(
  parameter int unsigned DN = 35,
  parameter int unsigned DD = 20
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DN-1:0] dividend_i,
  input  wire logic [DD-1:0] divisor_i,
  output logic      [DN-1:0] quotient_o,
  output div_stat_t          stat_o
);

  localparam int unsigned CntW = $clog2(DN + 1);

  logic [DD-1:0]   rem_q;
  logic [DN-1:0]   quo_q;
  logic [DD-1:0]   dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DD:0] trial;
  logic [DD:0] diff;
  logic        ge;

  assign trial = {rem_q, quo_q[DN-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvs_q  <= divisor_i;
      cnt_q  <= CntW'(DN);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DD-1:0] : trial[DD-1:0];
      quo_q <= {quo_q[DN-2:0], ge};
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

/* rtl/audio_mix_soft_limiter.sv */
// Audio mix step with soft gain-reduction limiter: top level and sequencer.
//
// Each transaction on the input channel is either a mix item (scale the source
// by the speaker gain, take 8/10, apply the limiter factor, add to the running
// mix sample, lower the factor when the sum passes the threshold) or a
// recovery tick that eases the factor back toward 1.0. One result comes out
// per item. Divisions by a constant (the full scale 2^(SAMPLE_BITS-1)-1, and
// 15 = 2^4-1, which carries the divides by 10 and by 10*65536) run on a shared
// fold unit that adds the high part of the operand onto its low part, one fold
// per clock; a multiplier with a registered product feeds it. The limiter's
// data-dependent division runs on a restoring divider, one quotient bit per
// clock, DN = max(2*SAMPLE_BITS-2, 35) bits wide. A mix item runs three fold
// passes; when the limiter engages it also waits for the divider. A tick runs
// one fold pass, or goes straight to the result when the factor is already
// near 1.0. A finished result waits in an output register until taken; the
// input is not ready while an item is in progress, so the next item may be
// taken while a result waits, but it cannot finish before that result leaves.
// The threshold register may be written at any time the block is idle;
// cfg_ready_o is always high.
`default_nettype none

module audio_mix_soft_limiter import amsl_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [14:0]        cfg_data_i,
  // input items
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic signed [15:0] acc_in_i,
  input  wire logic signed [15:0] src_sample_i,
  input  wire logic [15:0]        gain_i,
  // results
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      mixed_sample_o,
  output logic                    limited_o,
  output logic [16:0]             limit_factor_o
);

  `include "assert_macros.svh"

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned DivN = (2 * SB - 2 > 35) ? 2 * SB - 2 : 35;
  localparam int unsigned DivD = (SB > 20) ? SB : 20;
  localparam int unsigned MulA = (SB - 1 > 17) ? SB - 1 : 17;
  localparam int unsigned MulB = (SB - 1 > 20) ? SB - 1 : 20;
  localparam int unsigned SumW = SB + 1;

  localparam logic [SB-1:0] MaxV = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SumW-1:0] MaxS = $signed({2'b00, {(SB - 1){1'b1}}});
  localparam logic signed [SumW-1:0] MinS = -MaxS;

  // fold masks: divide by 2^(SB-1)-1 or by 15
  localparam logic [DivN-1:0] FoldMaskV  = DivN'(MaxV);
  localparam logic [DivN-1:0] FoldMask15 = DivN'(15);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIX_MUL1,
    S_MIX_DIV1,
    S_MIX_W1,
    S_MIX_DIV2,
    S_MIX_W2,
    S_MIX_MUL2,
    S_MIX_DIV3,
    S_MIX_W3,
    S_MIX_CMP,
    S_MIX_W4,
    S_TICK_MUL,
    S_TICK_DIV,
    S_TICK_W,
    S_FIN
  } state_e;

  state_e                 state_q;
  logic signed [15:0]     acc_q;
  logic signed [15:0]     src_q;
  logic [15:0]            gain_q;
  logic [14:0]            thr_q;
  logic [16:0]            factor_q;
  logic [SB-2:0]          mag_q;
  logic [DivN-1:0]        prod_q;
  logic signed [SumW-1:0] sum_q;
  logic                   lim_q;
  logic                   out_valid_q;
  logic signed [15:0]     mixed_q;
  logic                   limited_q;
  logic [16:0]            fac_out_q;

  // shared multiplier
  logic [MulA-1:0]      mul_a;
  logic [MulB-1:0]      mul_b;
  logic [MulA+MulB-1:0] mul_p;

  // shared fold unit for constant divisors
  logic            fold_load;
  logic            fold_k4;
  logic [DivN-1:0] fold_val;
  logic [DivN-1:0] fold_x_q;
  logic [DivN-1:0] fold_q_q;
  logic            fold_k4_q;
  logic [DivN-1:0] fold_mask;
  logic [DivN-1:0] fold_hi;
  logic [DivN-1:0] fold_lo;
  logic            fold_end;
  logic [DivN-1:0] fold_quo;
  logic [DivN-1:0] mag12;
  logic [DivN-1:0] tick_z;
  logic [DivN-1:0] tick3;

  // divider for the limiter
  logic            div_start;
  logic [DivN-1:0] div_num;
  logic [DivD-1:0] div_den;
  logic [DivN-1:0] quo;
  div_stat_t       div_stat;

  logic [15:0]            src_abs;
  logic [SB+15:0]         fac_wide;
  logic [SB-2:0]          fac_int;
  logic [16:0]            inv;
  logic [19:0]            inv_add;
  logic signed [SumW-1:0] part_pos;
  logic signed [SumW-1:0] part_s;
  logic signed [SumW-1:0] sum_neg;
  logic [SB-1:0]          sum_abs;
  logic                   over;
  logic signed [SumW-1:0] sum_sat;
  logic [16:0]            cand;

  assign src_abs  = src_q[15] ? 16'(-src_q) : 16'(src_q);
  // fac_int = (MAXV * factor) >> 16, MAXV = 2^(SB-1) - 1
  assign fac_wide = ((SB + 16)'(factor_q) << (SB - 1)) - (SB + 16)'(factor_q);
  assign fac_int  = fac_wide[SB+14:16];
  assign inv      = FacOne - factor_q;
  assign inv_add  = 20'(inv) + TickAdd;

  // x = hi*2^k + lo = hi*(2^k-1) + (hi+lo); fold until hi is zero
  assign fold_mask = fold_k4_q ? FoldMask15 : FoldMaskV;
  assign fold_hi   = fold_k4_q ? (fold_x_q >> 4) : (fold_x_q >> (SB - 1));
  assign fold_lo   = fold_x_q & fold_mask;
  assign fold_end  = (fold_hi == '0);
  assign fold_quo  = (fold_x_q == fold_mask) ? fold_q_q + DivN'(1) : fold_q_q;

  // 8*m/10 = 12*m/15; p/(10*65536) = (p >> 17)/5 = 3*(p >> 17)/15
  assign mag12  = DivN'({mag_q, 3'b000}) + DivN'({mag_q, 2'b00});
  assign tick_z = prod_q >> 17;
  assign tick3  = (tick_z << 1) + tick_z;

  // truncation toward zero: all divides work on magnitudes, sign follows src
  assign part_pos = $signed(SumW'(fold_quo[SB-2:0]));
  assign part_s   = src_q[15] ? -part_pos : part_pos;
  assign sum_neg  = -sum_q;
  assign sum_abs  = sum_q[SumW-1] ? sum_neg[SB-1:0] : sum_q[SB-1:0];
  assign over     = sum_abs > SB'(thr_q);
  assign sum_sat  = (sum_q > MaxS) ? MaxS : ((sum_q < MinS) ? MinS : sum_q);

  always_comb begin
    if (quo < DivN'(FacMin)) begin
      cand = FacMin;
    end else if (quo > DivN'(FacOne)) begin
      cand = FacOne;
    end else begin
      cand = quo[16:0];
    end
  end

  always_comb begin
    unique case (state_q)
      S_MIX_MUL1: begin
        mul_a = MulA'(src_abs);
        mul_b = MulB'(gain_q);
      end
      S_MIX_MUL2: begin
        mul_a = MulA'(mag_q);
        mul_b = MulB'(fac_int);
      end
      default: begin
        mul_a = MulA'(inv);
        mul_b = MulB'(inv_add);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    fold_load = 1'b0;
    fold_k4   = 1'b0;
    fold_val  = prod_q;
    unique case (state_q)
      S_MIX_DIV1, S_MIX_DIV3: begin
        fold_load = 1'b1;
      end
      S_MIX_DIV2: begin
        fold_load = 1'b1;
        fold_k4   = 1'b1;
        fold_val  = mag12;
      end
      S_TICK_DIV: begin
        fold_load = 1'b1;
        fold_k4   = 1'b1;
        fold_val  = tick3;
      end
      default: begin
        fold_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_x_q  <= '0;
      fold_q_q  <= '0;
      fold_k4_q <= 1'b0;
    end else if (fold_load) begin
      fold_x_q  <= fold_val;
      fold_q_q  <= '0;
      fold_k4_q <= fold_k4;
    end else if (!fold_end) begin
      fold_q_q <= fold_q_q + fold_hi;
      fold_x_q <= fold_hi + fold_lo;
    end
  end

  assign div_start = (state_q == S_MIX_CMP) && over;
  assign div_num   = DivN'({thr_q, 16'h0000});
  assign div_den   = DivD'(sum_abs);

  amsl_div #(
    .DN(DivN),
    .DD(DivD)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quotient_o (quo),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      src_q       <= '0;
      gain_q      <= '0;
      thr_q       <= ThreshReset;
      factor_q    <= FacOne;
      mag_q       <= '0;
      prod_q      <= '0;
      sum_q       <= '0;
      lim_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mixed_q     <= '0;
      limited_q   <= 1'b0;
      fac_out_q   <= FacOne;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      // S_FIN refills the output register itself
      if (out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            acc_q  <= acc_in_i;
            src_q  <= src_sample_i;
            gain_q <= gain_i;
            lim_q  <= 1'b0;
            sum_q  <= '0;
            if (!req_type_i) begin
              state_q <= S_MIX_MUL1;
            end else if (factor_q <= FacNearOne) begin
              state_q <= S_TICK_MUL;
            end else begin
              factor_q <= FacOne;
              state_q  <= S_FIN;
            end
          end
        end
        S_MIX_MUL1: begin
          prod_q  <= mul_p[DivN-1:0];
          state_q <= S_MIX_DIV1;
        end
        S_MIX_DIV1: state_q <= S_MIX_W1;
        S_MIX_W1: begin
          if (fold_end) begin
            mag_q   <= (fold_quo > DivN'(MaxV)) ? MaxV[SB-2:0] : fold_quo[SB-2:0];
            state_q <= S_MIX_DIV2;
          end
        end
        S_MIX_DIV2: state_q <= S_MIX_W2;
        S_MIX_W2: begin
          if (fold_end) begin
            mag_q   <= fold_quo[SB-2:0];
            state_q <= S_MIX_MUL2;
          end
        end
        S_MIX_MUL2: begin
          prod_q  <= mul_p[DivN-1:0];
          state_q <= S_MIX_DIV3;
        end
        S_MIX_DIV3: state_q <= S_MIX_W3;
        S_MIX_W3: begin
          if (fold_end) begin
            sum_q   <= SumW'(acc_q) + part_s;
            state_q <= S_MIX_CMP;
          end
        end
        S_MIX_CMP: begin
          lim_q   <= over;
          state_q <= over ? S_MIX_W4 : S_FIN;
        end
        S_MIX_W4: begin
          if (div_stat.done) begin
            if (cand < factor_q) begin
              factor_q <= cand;
            end
            state_q <= S_FIN;
          end
        end
        S_TICK_MUL: begin
          prod_q  <= mul_p[DivN-1:0];
          state_q <= S_TICK_DIV;
        end
        S_TICK_DIV: state_q <= S_TICK_W;
        S_TICK_W: begin
          if (fold_end) begin
            factor_q <= FacOne - fold_quo[16:0];
            state_q  <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            mixed_q     <= sum_sat[15:0];
            limited_q   <= lim_q;
            fac_out_q   <= factor_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mixed_q;
  assign limited_o      = limited_q;
  assign limit_factor_o = fac_out_q;

  `ASSERT_AT(a_factor_range, clk_i, rst_ni, (factor_q >= FacMin) && (factor_q <= FacOne))
  `ASSERT_NEVER(a_idle_div_quiet, clk_i, rst_ni, (state_q == S_IDLE) && div_stat.busy)
  `ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, div_start && div_stat.busy)

endmodule

`default_nettype wire
